// File: hdl/rthsv_pkg.sv
// Shared types for the RGB to HSV pixel pipeline.
// No dependencies; imported by every stage module and the top level.
package rthsv_pkg;

   // Handshake seen by one pipeline stage: valid from the stage above,
   // ready from the stage below.
   typedef struct packed {
      logic up_valid;
      logic down_ready;
   } link_type;

endpackage

// File: hdl/rgb_to_hsv_pixel.sv
// RGB to HSV pixel converter: a preparation stage followed by FRACTION_BITS
// long-division stages, each resolving one quotient bit of hue and saturation.
// One transaction enters per cycle while req_stall is low, and bubbles close up
// under backpressure. Synchronous reset clears the stage valid bits and holds
// off input while asserted.
// Depends on rthsv_pkg, rthsv_prep and rthsv_div_step.
module rgb_to_hsv_pixel
   import rthsv_pkg::*;
#(
   parameter int PIXEL_BITS    = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PIXEL_BITS-1:0]    req_red,
   input  logic [PIXEL_BITS-1:0]    req_green,
   input  logic [PIXEL_BITS-1:0]    req_blue,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [FRACTION_BITS-1:0] rsp_hue,
   output logic [FRACTION_BITS-1:0] rsp_saturation,
   output logic [PIXEL_BITS-1:0]    rsp_brightness
);

   localparam int DW = PIXEL_BITS + 3;
   localparam int NS = FRACTION_BITS;

   logic                     valid   [0:NS];
   logic                     ready   [0:NS+1];
   logic [DW-1:0]            hue_rem [0:NS];
   logic [DW-1:0]            hue_div [0:NS];
   logic [FRACTION_BITS-1:0] hue_quo [0:NS];
   logic [PIXEL_BITS-1:0]    sat_rem [0:NS];
   logic [PIXEL_BITS-1:0]    sat_div [0:NS];
   logic [FRACTION_BITS-1:0] sat_acc [0:NS];
   logic [PIXEL_BITS-1:0]    bright  [0:NS];
   link_type                 link    [0:NS];

   assign ready[NS+1] = !rsp_stall;
   assign req_stall   = !ready[0] || reset;
   assign hue_quo[0]  = '0;

   assign link[0] = '{up_valid: req_valid, down_ready: ready[1]};

   rthsv_prep #(
      .PIXEL_BITS    (PIXEL_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .ctl        (link[0]),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .valid      (valid[0]),
      .ready      (ready[0]),
      .hue_rem    (hue_rem[0]),
      .hue_div    (hue_div[0]),
      .sat_rem    (sat_rem[0]),
      .sat_div    (sat_div[0]),
      .sat_acc    (sat_acc[0]),
      .brightness (bright[0])
   );

   for (genvar k = 1; k <= NS; k++) begin : g_step
      assign link[k] = '{up_valid: valid[k-1], down_ready: ready[k+1]};

      rthsv_div_step #(
         .PIXEL_BITS    (PIXEL_BITS),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_step (
         .clock         (clock),
         .reset         (reset),
         .ctl           (link[k]),
         .up_hue_rem    (hue_rem[k-1]),
         .up_hue_div    (hue_div[k-1]),
         .up_hue_quo    (hue_quo[k-1]),
         .up_sat_rem    (sat_rem[k-1]),
         .up_sat_div    (sat_div[k-1]),
         .up_sat_acc    (sat_acc[k-1]),
         .up_brightness (bright[k-1]),
         .valid         (valid[k]),
         .ready         (ready[k]),
         .hue_rem       (hue_rem[k]),
         .hue_div       (hue_div[k]),
         .hue_quo       (hue_quo[k]),
         .sat_rem       (sat_rem[k]),
         .sat_div       (sat_div[k]),
         .sat_acc       (sat_acc[k]),
         .brightness    (bright[k])
      );
   end

   assign rsp_valid      = valid[NS];
   assign rsp_hue        = hue_quo[NS];
   assign rsp_saturation = sat_acc[NS];
   assign rsp_brightness = bright[NS];

   // A finished division always leaves a remainder below its divisor.
   a_hue_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid[NS] |-> hue_rem[NS] < hue_div[NS])
      else $error("hue remainder not below divisor");

   a_sat_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid[NS] |-> sat_rem[NS] < sat_div[NS])
      else $error("saturation remainder not below divisor");

   a_black_pixel: assert property (@(posedge clock) disable iff (reset)
      valid[NS] && rsp_brightness == '0 |-> rsp_hue == '0 && rsp_saturation == '0)
      else $error("black pixel with nonzero hue or saturation");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid[0])
      else $error("accepted transaction did not reach the first stage");

endmodule

// File: hdl/rthsv_prep.sv
// First pipeline stage: max, min, delta, hue sector offset and the
// saturation numerator, registered. Depends on rthsv_pkg.
module rthsv_prep
   import rthsv_pkg::*;
#(
   parameter int PIXEL_BITS    = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  link_type                    ctl,
   input  logic [PIXEL_BITS-1:0]       red,
   input  logic [PIXEL_BITS-1:0]       green,
   input  logic [PIXEL_BITS-1:0]       blue,
   output logic                        valid,
   output logic                        ready,
   output logic [PIXEL_BITS+2:0]       hue_rem,
   output logic [PIXEL_BITS+2:0]       hue_div,
   output logic [PIXEL_BITS-1:0]       sat_rem,
   output logic [PIXEL_BITS-1:0]       sat_div,
   output logic [FRACTION_BITS-1:0]    sat_acc,
   output logic [PIXEL_BITS-1:0]       brightness
);

   localparam int DW = PIXEL_BITS + 3;
   localparam int NW = PIXEL_BITS + FRACTION_BITS;

   logic                     valid_ff, valid_in;
   logic [DW-1:0]            hue_rem_ff, hue_rem_in;
   logic [DW-1:0]            hue_div_ff, hue_div_in;
   logic [PIXEL_BITS-1:0]    sat_rem_ff, sat_rem_in;
   logic [PIXEL_BITS-1:0]    sat_div_ff, sat_div_in;
   logic [FRACTION_BITS-1:0] sat_acc_ff, sat_acc_in;
   logic [PIXEL_BITS-1:0]    bright_ff, bright_in;

   logic [PIXEL_BITS-1:0]    max_c, min_c, delta_c;
   logic [DW-1:0]            delta_x, six_delta;
   logic [NW-1:0]            sat_num;

   assign ready = !valid_ff || ctl.down_ready;

   always_comb begin
      max_c = red;
      min_c = red;
      if (green > max_c) max_c = green;
      if (blue > max_c) max_c = blue;
      if (green < min_c) min_c = green;
      if (blue < min_c) min_c = blue;
      delta_c   = max_c - min_c;
      delta_x   = DW'(delta_c);
      six_delta = (delta_x << 2) + (delta_x << 1);

      // A grey pixel gets an all-ones divisor so that every quotient bit is zero.
      if (delta_c == '0) begin
         hue_rem_in = '0;
         hue_div_in = '1;
      end else begin
         hue_div_in = six_delta;
         if (max_c == red) begin
            if (green >= blue) begin
               hue_rem_in = DW'(green - blue);
            end else begin
               hue_rem_in = six_delta - DW'(blue - green);
            end
         end else if (max_c == green) begin
            hue_rem_in = (delta_x << 1) + DW'(blue) - DW'(red);
         end else begin
            hue_rem_in = (delta_x << 2) + DW'(red) - DW'(green);
         end
      end

      // The numerator is delta times the largest fraction code; its upper part
      // is already below the divisor sat_div_in, so the long division starts from it.
      sat_num    = {delta_c, {FRACTION_BITS{1'b0}}} - NW'(delta_c);
      sat_rem_in = sat_num[NW-1:FRACTION_BITS];
      sat_acc_in = sat_num[FRACTION_BITS-1:0];
      sat_div_in = (max_c == '0) ? '1 : max_c;
      bright_in  = max_c;
      valid_in   = ready ? ctl.up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         hue_rem_ff <= hue_rem_in;
         hue_div_ff <= hue_div_in;
         sat_rem_ff <= sat_rem_in;
         sat_div_ff <= sat_div_in;
         sat_acc_ff <= sat_acc_in;
         bright_ff  <= bright_in;
      end
   end

   assign valid      = valid_ff;
   assign hue_rem    = hue_rem_ff;
   assign hue_div    = hue_div_ff;
   assign sat_rem    = sat_rem_ff;
   assign sat_div    = sat_div_ff;
   assign sat_acc    = sat_acc_ff;
   assign brightness = bright_ff;

endmodule

// File: hdl/rthsv_div_step.sv
// One long-division stage: produces one quotient bit of hue and one of
// saturation, registered. Depends on rthsv_pkg.
module rthsv_div_step
   import rthsv_pkg::*;
#(
   parameter int PIXEL_BITS    = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  link_type                    ctl,
   input  logic [PIXEL_BITS+2:0]       up_hue_rem,
   input  logic [PIXEL_BITS+2:0]       up_hue_div,
   input  logic [FRACTION_BITS-1:0]    up_hue_quo,
   input  logic [PIXEL_BITS-1:0]       up_sat_rem,
   input  logic [PIXEL_BITS-1:0]       up_sat_div,
   input  logic [FRACTION_BITS-1:0]    up_sat_acc,
   input  logic [PIXEL_BITS-1:0]       up_brightness,
   output logic                        valid,
   output logic                        ready,
   output logic [PIXEL_BITS+2:0]       hue_rem,
   output logic [PIXEL_BITS+2:0]       hue_div,
   output logic [FRACTION_BITS-1:0]    hue_quo,
   output logic [PIXEL_BITS-1:0]       sat_rem,
   output logic [PIXEL_BITS-1:0]       sat_div,
   output logic [FRACTION_BITS-1:0]    sat_acc,
   output logic [PIXEL_BITS-1:0]       brightness
);

   localparam int DW = PIXEL_BITS + 3;

   logic                     valid_ff, valid_in;
   logic [DW-1:0]            hue_rem_ff, hue_rem_in;
   logic [DW-1:0]            hue_div_ff;
   logic [FRACTION_BITS-1:0] hue_quo_ff, hue_quo_in;
   logic [PIXEL_BITS-1:0]    sat_rem_ff, sat_rem_in;
   logic [PIXEL_BITS-1:0]    sat_div_ff;
   logic [FRACTION_BITS-1:0] sat_acc_ff, sat_acc_in;
   logic [PIXEL_BITS-1:0]    bright_ff;

   logic [DW:0]              hue_trial;
   logic [PIXEL_BITS:0]      sat_trial;
   logic                     hue_bit, sat_bit;

   assign ready = !valid_ff || ctl.down_ready;

   always_comb begin
      hue_trial = {up_hue_rem, 1'b0};
      hue_bit   = hue_trial >= {1'b0, up_hue_div};
      hue_rem_in = hue_bit ? DW'(hue_trial - {1'b0, up_hue_div}) : hue_trial[DW-1:0];
      hue_quo_in = {up_hue_quo[FRACTION_BITS-2:0], hue_bit};

      sat_trial = {up_sat_rem, up_sat_acc[FRACTION_BITS-1]};
      sat_bit   = sat_trial >= {1'b0, up_sat_div};
      sat_rem_in = sat_bit ? PIXEL_BITS'(sat_trial - {1'b0, up_sat_div})
                           : sat_trial[PIXEL_BITS-1:0];
      sat_acc_in = {up_sat_acc[FRACTION_BITS-2:0], sat_bit};

      valid_in = ready ? ctl.up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         hue_rem_ff <= hue_rem_in;
         hue_div_ff <= up_hue_div;
         hue_quo_ff <= hue_quo_in;
         sat_rem_ff <= sat_rem_in;
         sat_div_ff <= up_sat_div;
         sat_acc_ff <= sat_acc_in;
         bright_ff  <= up_brightness;
      end
   end

   assign valid      = valid_ff;
   assign hue_rem    = hue_rem_ff;
   assign hue_div    = hue_div_ff;
   assign hue_quo    = hue_quo_ff;
   assign sat_rem    = sat_rem_ff;
   assign sat_div    = sat_div_ff;
   assign sat_acc    = sat_acc_ff;
   assign brightness = bright_ff;

endmodule

// File: tb/tb.sv
// Self-checking testbench for rgb_to_hsv_pixel: directed and random pixels under mixed
// input and output backpressure, each result compared with an in-bench HSV predictor.
// Depends on rgb_to_hsv_pixel.
module tb;

   localparam int PIXEL_BITS    = 8;
   localparam int FRACTION_BITS = 16;
   localparam int PIXEL_MAX     = (1 << PIXEL_BITS) - 1;

   typedef struct packed {
      logic [FRACTION_BITS-1:0] hue;
      logic [FRACTION_BITS-1:0] saturation;
      logic [PIXEL_BITS-1:0]    brightness;
   } hsv_result_type;

   class hsv_scoreboard_type;
      hsv_result_type expected_hsv[$];
      int             failures;
      int             pixels_in;
      int             results_checked;
      int             grey_pixels;
      int             red_max;
      int             green_max;
      int             blue_max;

      function hsv_result_type hsv_of(input logic [PIXEL_BITS-1:0] r, g, b);
         int unsigned ri;
         int unsigned gi;
         int unsigned bi;
         int unsigned top;
         int unsigned bottom;
         int unsigned delta;
         int unsigned num;
         int unsigned hue_full;
         int unsigned sat_full;
         hsv_result_type res;
         ri = 32'(r);
         gi = 32'(g);
         bi = 32'(b);
         top = ri;
         if (gi > top) top = gi;
         if (bi > top) top = bi;
         bottom = ri;
         if (gi < bottom) bottom = gi;
         if (bi < bottom) bottom = bi;
         delta = top - bottom;
         hue_full = 0;
         sat_full = 0;
         if (delta != 0) begin
            if (top == ri) begin
               if (gi >= bi) num = gi - bi;
               else num = 6 * delta - (bi - gi);
            end else if (top == gi) begin
               num = 2 * delta + bi - ri;
            end else begin
               num = 4 * delta + ri - gi;
            end
            hue_full = (num << FRACTION_BITS) / (6 * delta);
         end
         if (top != 0) sat_full = (delta * ((1 << FRACTION_BITS) - 1)) / top;
         res.hue        = hue_full[FRACTION_BITS-1:0];
         res.saturation = sat_full[FRACTION_BITS-1:0];
         res.brightness = top[PIXEL_BITS-1:0];
         return res;
      endfunction

      function void note_pixel(input logic [PIXEL_BITS-1:0] r, g, b);
         expected_hsv.insert(expected_hsv.size(), hsv_of(r, g, b));
         pixels_in++;
         if (r == g && g == b) grey_pixels++;
         else if (r >= g && r >= b) red_max++;
         else if (g >= b) green_max++;
         else blue_max++;
      endfunction

      function void check_result(input hsv_result_type actual);
         hsv_result_type want;
         if (expected_hsv.size() == 0) begin
            $display("%0t: unexpected result, hue %0d saturation %0d brightness %0d",
                     $time, actual.hue, actual.saturation, actual.brightness);
            failures++;
            return;
         end
         want = expected_hsv.pop_front();
         results_checked++;
         if (actual.hue !== want.hue) begin
            $display("%0t: hue mismatch, expected %0d, actual %0d",
                     $time, want.hue, actual.hue);
            failures++;
         end
         if (actual.saturation !== want.saturation) begin
            $display("%0t: saturation mismatch, expected %0d, actual %0d",
                     $time, want.saturation, actual.saturation);
            failures++;
         end
         if (actual.brightness !== want.brightness) begin
            $display("%0t: brightness mismatch, expected %0d, actual %0d",
                     $time, want.brightness, actual.brightness);
            failures++;
         end
      endfunction

      function int pending();
         return expected_hsv.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [PIXEL_BITS-1:0]    req_red = '0;
   logic [PIXEL_BITS-1:0]    req_green = '0;
   logic [PIXEL_BITS-1:0]    req_blue = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [FRACTION_BITS-1:0] rsp_hue;
   logic [FRACTION_BITS-1:0] rsp_saturation;
   logic [PIXEL_BITS-1:0]    rsp_brightness;

   hsv_scoreboard_type hsv_board;
   int                 sender_gap_pct;
   int                 receiver_stall_pct;
   int                 hold_cycles;

   rgb_to_hsv_pixel #(
      .PIXEL_BITS(PIXEL_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hue(rsp_hue),
      .rsp_saturation(rsp_saturation),
      .rsp_brightness(rsp_brightness)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // The receiver either holds off for a counted stretch or stalls at random.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         hsv_board.check_result({rsp_hue, rsp_saturation, rsp_brightness});
      end
   end

   task automatic send_pixel(input logic [PIXEL_BITS-1:0] r, g, b);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hsv_board.note_pixel(r, g, b);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (hsv_board.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [PIXEL_BITS-1:0] edge_code();
      case ($urandom_range(3))
         0: return '0;
         1: return PIXEL_BITS'(1);
         2: return PIXEL_BITS'(PIXEL_MAX - 1);
         default: return PIXEL_BITS'(PIXEL_MAX);
      endcase
   endfunction

   // Most pixels are uniform, the rest are biased toward grey, ties and extreme codes.
   task automatic send_random_pixel();
      logic [PIXEL_BITS-1:0] r, g, b, tie;
      r = PIXEL_BITS'($urandom_range(PIXEL_MAX));
      g = PIXEL_BITS'($urandom_range(PIXEL_MAX));
      b = PIXEL_BITS'($urandom_range(PIXEL_MAX));
      tie = PIXEL_BITS'($urandom_range(PIXEL_MAX));
      case ($urandom_range(9))
         5: begin
            g = r;
            b = r;
         end
         6: begin
            case ($urandom_range(2))
               0: begin r = tie; g = tie; b = PIXEL_BITS'($urandom_range(tie)); end
               1: begin g = tie; b = tie; r = PIXEL_BITS'($urandom_range(tie)); end
               default: begin r = tie; b = tie; g = PIXEL_BITS'($urandom_range(tie)); end
            endcase
         end
         7: begin
            r = edge_code();
            g = edge_code();
            b = edge_code();
         end
         8: begin
            r = PIXEL_BITS'($urandom_range(3));
            g = PIXEL_BITS'($urandom_range(3));
            b = PIXEL_BITS'($urandom_range(3));
         end
         default: ;
      endcase
      send_pixel(r, g, b);
   endtask

   initial begin
      hsv_board = new();
      sender_gap_pct = 0;
      receiver_stall_pct = 0;
      hold_cycles = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_gap_pct = 22;
      receiver_stall_pct = 88;
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd1, 8'd1);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd1, 8'd0);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd1, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd254, 8'd255, 8'd254);
      send_pixel(8'd0, 8'd254, 8'd255);
      send_pixel(8'd200, 8'd100, 8'd200);
      send_pixel(8'd100, 8'd200, 8'd200);
      send_pixel(8'd170, 8'd85, 8'd0);
      repeat (160) send_random_pixel();

      sender_gap_pct = 88;
      receiver_stall_pct = 22;
      repeat (180) send_random_pixel();
      wait_drained();

      sender_gap_pct = 0;
      receiver_stall_pct = 0;
      hold_cycles = 150;
      repeat (200) send_random_pixel();
      wait_drained();

      repeat (40) @(posedge clock);
      $display("Converted %0d pixels: %0d grey, %0d red max, %0d green max, %0d blue max.",
               hsv_board.pixels_in, hsv_board.grey_pixels, hsv_board.red_max,
               hsv_board.green_max, hsv_board.blue_max);
      $display("Checked %0d results across three idle mixes and a long output hold.",
               hsv_board.results_checked);
      if (hsv_board.failures == 0 && hsv_board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// File: filelist.f
hdl/rthsv_pkg.sv
hdl/rthsv_prep.sv
hdl/rthsv_div_step.sv
hdl/rgb_to_hsv_pixel.sv
tb/tb.sv
